FILE: rtl/core/tgarle_pkg.sv
package tgarle_pkg;

	localparam int unsigned HDR_LEN = 18;
	localparam logic [4:0] OFF_KIND = 5'd2;
	localparam logic [4:0] OFF_WIDTH_LO = 5'd12;
	localparam logic [4:0] OFF_WIDTH_HI = 5'd13;
	localparam logic [4:0] OFF_HEIGHT_LO = 5'd14;
	localparam logic [4:0] OFF_HEIGHT_HI = 5'd15;
	localparam logic [4:0] OFF_BPP = 5'd16;
	localparam logic [4:0] OFF_DATA = 5'(HDR_LEN);

	localparam logic [7:0] KIND_RAW = 8'd2;
	localparam logic [7:0] KIND_RLE = 8'd10;
	localparam logic [7:0] BPP_32 = 8'd32;

	localparam logic [1:0] ST_PIXEL = 2'd0;
	localparam logic [1:0] ST_SIZE = 2'd1;
	localparam logic [1:0] ST_KIND = 2'd2;

	localparam logic REG_WIDTH = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;

	typedef enum logic [4:0] {
		PH_HEADER = 5'b00001,
		PH_RAW    = 5'b00010,
		PH_PACKET = 5'b00100,
		PH_COLOR  = 5'b01000,
		PH_DONE   = 5'b10000
	} phase_t;

	typedef struct packed {
		logic [7:0] file_byte;
		logic       first_byte;
	} in_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] pixel_index;
		logic [7:0]  repeat_count;
		logic [7:0]  blue;
		logic [7:0]  green;
		logic [7:0]  red;
		logic [7:0]  alpha;
		logic        image_done;
	} out_t;

	typedef struct packed {
		logic [15:0] expected_width;
		logic [15:0] expected_height;
	} cfg_t;

endpackage

FILE: rtl/core/tgarle_parse.sv
module tgarle_parse (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              advance,
	input  tgarle_pkg::in_t   item,
	input  tgarle_pkg::cfg_t  cfg,
	output logic              has_result,
	output tgarle_pkg::out_t  result
);

	tgarle_pkg::phase_t phase_q, phase_n, eff_phase;
	logic [4:0]  offset_q, offset_n, eff_offset;
	logic [7:0]  kind_q, kind_n;
	logic [15:0] width_q, width_n;
	logic [15:0] height_q, height_n;
	logic [7:0]  bpp_q, bpp_n;
	logic [7:0]  left_q, left_n;
	logic        run_q, run_n;
	logic [1:0]  chan_q, chan_n;
	logic [23:0] color_q, color_n;
	logic [31:0] done_q, done_n;
	logic [31:0] total_q;

	logic [7:0]  b;
	logic [7:0]  pk_len;
	logic [31:0] pk_rem;
	logic [31:0] pk_rem_base;
	logic        pk_decode;
	logic [7:0]  pk_left;
	logic [7:0]  px_count;
	logic [31:0] px_next;
	logic        px_last;

	assign b = item.file_byte;
	assign eff_phase = item.first_byte ? tgarle_pkg::PH_HEADER : phase_q;
	assign eff_offset = item.first_byte ? 5'd0 : offset_q;

	// packet header decode, shared by the first data byte and later packets
	assign pk_len = {1'b0, b[6:0]} + 8'd1;
	assign pk_rem_base = (eff_phase == tgarle_pkg::PH_HEADER) ? 32'd0 : done_q;
	assign pk_rem = total_q - pk_rem_base;
	assign pk_left = ({24'd0, pk_len} > pk_rem) ? pk_rem[7:0] : pk_len;

	// pixel emit
	assign px_count = (eff_phase == tgarle_pkg::PH_COLOR && run_q) ? left_q : 8'd1;
	assign px_next = done_q + {24'd0, px_count};
	assign px_last = px_next >= total_q;

	always_comb begin
		phase_n = eff_phase;
		offset_n = eff_offset;
		kind_n = kind_q;
		width_n = width_q;
		height_n = height_q;
		bpp_n = bpp_q;
		left_n = left_q;
		run_n = run_q;
		chan_n = chan_q;
		color_n = color_q;
		done_n = done_q;
		pk_decode = 1'b0;
		has_result = 1'b0;
		result = '0;
		case (eff_phase)
			tgarle_pkg::PH_HEADER: begin
				if (eff_offset < tgarle_pkg::OFF_DATA) begin
					case (eff_offset)
						tgarle_pkg::OFF_KIND: kind_n = b;
						tgarle_pkg::OFF_WIDTH_LO: width_n = {width_q[15:8], b};
						tgarle_pkg::OFF_WIDTH_HI: width_n = {b, width_q[7:0]};
						tgarle_pkg::OFF_HEIGHT_LO: height_n = {height_q[15:8], b};
						tgarle_pkg::OFF_HEIGHT_HI: height_n = {b, height_q[7:0]};
						tgarle_pkg::OFF_BPP: bpp_n = b;
						default: ;
					endcase
					offset_n = eff_offset + 5'd1;
				end else if (width_q != cfg.expected_width ||
				             height_q != cfg.expected_height ||
				             bpp_q != tgarle_pkg::BPP_32) begin
					phase_n = tgarle_pkg::PH_DONE;
					has_result = 1'b1;
					result.status = tgarle_pkg::ST_SIZE;
				end else if (kind_q != tgarle_pkg::KIND_RAW &&
				             kind_q != tgarle_pkg::KIND_RLE) begin
					phase_n = tgarle_pkg::PH_DONE;
					has_result = 1'b1;
					result.status = tgarle_pkg::ST_KIND;
				end else begin
					done_n = '0;
					left_n = '0;
					run_n = 1'b0;
					color_n = '0;
					if (total_q == 32'd0) begin
						phase_n = tgarle_pkg::PH_DONE;
					end else if (kind_q == tgarle_pkg::KIND_RAW) begin
						phase_n = tgarle_pkg::PH_RAW;
						color_n = {16'd0, b};
						chan_n = 2'd1;
					end else begin
						pk_decode = 1'b1;
					end
				end
			end
			tgarle_pkg::PH_PACKET: begin
				pk_decode = 1'b1;
			end
			tgarle_pkg::PH_RAW, tgarle_pkg::PH_COLOR: begin
				if (chan_q != 2'd3) begin
					case (chan_q)
						2'd0: color_n[7:0] = b;
						2'd1: color_n[15:8] = b;
						default: color_n[23:16] = b;
					endcase
					chan_n = chan_q + 2'd1;
				end else begin
					has_result = 1'b1;
					result.status = tgarle_pkg::ST_PIXEL;
					result.pixel_index = done_q;
					result.repeat_count = px_count;
					result.blue = color_q[7:0];
					result.green = color_q[15:8];
					result.red = color_q[23:16];
					result.alpha = b;
					result.image_done = px_last;
					chan_n = 2'd0;
					color_n = '0;
					done_n = px_next;
					if (eff_phase == tgarle_pkg::PH_COLOR) begin
						if (run_q) begin
							left_n = '0;
							phase_n = tgarle_pkg::PH_PACKET;
						end else begin
							left_n = left_q - 8'd1;
							if (left_q == 8'd1) begin
								phase_n = tgarle_pkg::PH_PACKET;
							end
						end
					end
					if (px_last) begin
						phase_n = tgarle_pkg::PH_DONE;
					end
				end
			end
			default: ;
		endcase
		if (pk_decode) begin
			run_n = b[7];
			left_n = pk_left;
			chan_n = 2'd0;
			color_n = '0;
			phase_n = tgarle_pkg::PH_COLOR;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= tgarle_pkg::PH_HEADER;
			offset_q <= '0;
			kind_q <= '0;
			width_q <= '0;
			height_q <= '0;
			bpp_q <= '0;
			left_q <= '0;
			run_q <= 1'b0;
			chan_q <= '0;
			color_q <= '0;
			done_q <= '0;
			total_q <= '0;
		end else begin
			// product is registered every clock from the stored width and height
			total_q <= {16'd0, width_q} * {16'd0, height_q};
			if (advance) begin
				phase_q <= phase_n;
				offset_q <= offset_n;
				kind_q <= kind_n;
				width_q <= width_n;
				height_q <= height_n;
				bpp_q <= bpp_n;
				left_q <= left_n;
				run_q <= run_n;
				chan_q <= chan_n;
				color_q <= color_n;
				done_q <= done_n;
			end
		end
	end

endmodule

FILE: rtl/core/tga_rle_image_decoder.sv
// A result beat is registered: the input register feeds the parser, and the result register
// loads when the held byte advances.
// Throughput: one file byte per clock while result beats are taken; a result beat left
// waiting holds the byte behind it, and the input stalls until that beat is taken.
// Reset: arst_n clears the parser to header offset 0, the header fields and counters,
// and sets both expected size registers to 1; no clearing pass is needed.
module tga_rle_image_decoder (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              byte_valid,
	output logic              byte_ready,
	input  tgarle_pkg::in_t   byte_data,
	output logic              pix_valid,
	input  logic              pix_ready,
	output tgarle_pkg::out_t  pix_data,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [2:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	tgarle_pkg::cfg_t cfg_q;
	tgarle_pkg::in_t  item_s1;
	logic             valid_s1;
	logic             advance;
	logic             has_result;
	tgarle_pkg::out_t result;
	tgarle_pkg::out_t pix_data_q;
	logic             pix_valid_q;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == tgarle_pkg::REG_HEIGHT) ?
	                {16'd0, cfg_q.expected_height} : {16'd0, cfg_q.expected_width};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.expected_width <= 16'd1;
			cfg_q.expected_height <= 16'd1;
		end else if (psel && penable && pwrite && pready) begin
			if (paddr[2] == tgarle_pkg::REG_WIDTH) begin
				cfg_q.expected_width <= pwdata[15:0];
			end else begin
				cfg_q.expected_height <= pwdata[15:0];
			end
		end
	end

	// the held byte advances when the result slot is free or being drained
	assign advance = valid_s1 && (!pix_valid_q || pix_ready);
	assign byte_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_ready) begin
			valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_ready && byte_valid) begin
			item_s1 <= byte_data;
		end
	end

	tgarle_parse u_parse (
		.clk        (clk),
		.arst_n     (arst_n),
		.advance    (advance),
		.item       (item_s1),
		.cfg        (cfg_q),
		.has_result (has_result),
		.result     (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_valid_q <= 1'b0;
		end else if (advance) begin
			pix_valid_q <= has_result;
		end else if (pix_ready) begin
			pix_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && has_result) begin
			pix_data_q <= result;
		end
	end

	assign pix_valid = pix_valid_q;
	assign pix_data = pix_data_q;

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!byte_ready |-> (valid_s1 && pix_valid && !pix_ready))
		else $error("input stalled without a blocked result beat");

	a_count_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(pix_valid && pix_data.status == tgarle_pkg::ST_PIXEL) |-> (pix_data.repeat_count != 8'd0))
		else $error("pixel beat with zero repeat count");

	a_error_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(pix_valid && pix_data.status != tgarle_pkg::ST_PIXEL) |->
		(pix_data.repeat_count == 8'd0 && !pix_data.image_done && pix_data.pixel_index == 32'd0))
		else $error("error beat carries pixel fields");

endmodule

FILE: bench/tga_rle_image_decoder_tb.sv
`timescale 1ns / 1ps

module tga_rle_image_decoder_tb;

	localparam int NUM_PHASES = 8;
	localparam int ITEMS_PER_PHASE = 170;
	localparam int MAX_PACKETS = 16;
	localparam int SETTLE_CYCLES = 6;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic byte_valid = 1'b0;
	logic byte_ready;
	tgarle_pkg::in_t byte_data = '0;
	logic pix_valid;
	logic pix_ready = 1'b0;
	tgarle_pkg::out_t pix_data;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	tga_rle_image_decoder DUT (
		.clk(clk),
		.arst_n(arst_n),
		.byte_valid(byte_valid),
		.byte_ready(byte_ready),
		.byte_data(byte_data),
		.pix_valid(pix_valid),
		.pix_ready(pix_ready),
		.pix_data(pix_data),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	tgarle_pkg::in_t file_bytes[$];
	tgarle_pkg::out_t pixel_expect[$];

	int tx_idle_pct = 0;
	int rx_stall_pct = 0;
	logic byte_taken = 1'b0;
	int phase_items = 0;

	int mismatches = 0;
	int bytes_in = 0;
	int files_sent = 0;
	int pixel_beats = 0;
	int run_beats = 0;
	int images_done = 0;
	int header_rejects = 0;

	// decoder state as the block should hold it
	tgarle_pkg::cfg_t size_cfg = '{expected_width: 16'd1, expected_height: 16'd1};
	logic [4:0] hdr_off = '0;
	logic [7:0] img_kind = '0;
	logic [15:0] hdr_w = '0;
	logic [15:0] hdr_h = '0;
	logic [7:0] hdr_bpp = '0;
	tgarle_pkg::phase_t dec_phase = tgarle_pkg::PH_HEADER;
	logic [7:0] pkt_left = '0;
	logic pkt_run = 1'b0;
	logic [1:0] chan_idx = '0;
	logic [23:0] color_acc = '0;
	logic [31:0] pix_count = '0;

	initial begin
		forever #4 clk = ~clk;
	end

	initial begin
		#5ms;
		$display("[tga_rle_image_decoder] ERROR");
		$finish;
	end

	task automatic decode_byte(input tgarle_pkg::in_t beat, output logic hit,
			output tgarle_pkg::out_t res);
		logic [7:0] b;
		logic [31:0] tot;
		logic [31:0] left;
		logic [7:0] cnt;
		logic go_packet;
		logic emit;
		b = beat.file_byte;
		tot = 32'(hdr_w) * 32'(hdr_h);
		hit = 1'b0;
		res = '0;
		go_packet = 1'b0;
		emit = 1'b0;
		cnt = 8'd1;
		if (beat.first_byte) begin
			hdr_off = '0;
			dec_phase = tgarle_pkg::PH_HEADER;
		end
		case (dec_phase)
			tgarle_pkg::PH_HEADER: begin
				if (hdr_off < tgarle_pkg::OFF_DATA) begin
					case (hdr_off)
						tgarle_pkg::OFF_KIND: img_kind = b;
						tgarle_pkg::OFF_WIDTH_LO: hdr_w[7:0] = b;
						tgarle_pkg::OFF_WIDTH_HI: hdr_w[15:8] = b;
						tgarle_pkg::OFF_HEIGHT_LO: hdr_h[7:0] = b;
						tgarle_pkg::OFF_HEIGHT_HI: hdr_h[15:8] = b;
						tgarle_pkg::OFF_BPP: hdr_bpp = b;
						default: ;
					endcase
					hdr_off = hdr_off + 5'd1;
				end else if (hdr_w != size_cfg.expected_width
						|| hdr_h != size_cfg.expected_height
						|| hdr_bpp != tgarle_pkg::BPP_32) begin
					dec_phase = tgarle_pkg::PH_DONE;
					hit = 1'b1;
					res.status = tgarle_pkg::ST_SIZE;
				end else if (img_kind != tgarle_pkg::KIND_RAW
						&& img_kind != tgarle_pkg::KIND_RLE) begin
					dec_phase = tgarle_pkg::PH_DONE;
					hit = 1'b1;
					res.status = tgarle_pkg::ST_KIND;
				end else begin
					pix_count = '0;
					pkt_left = '0;
					pkt_run = 1'b0;
					color_acc = '0;
					if (tot == 0) begin
						dec_phase = tgarle_pkg::PH_DONE;
					end else if (img_kind == tgarle_pkg::KIND_RAW) begin
						dec_phase = tgarle_pkg::PH_RAW;
						color_acc = {16'd0, b};
						chan_idx = 2'd1;
					end else begin
						// this byte is already the first packet header
						go_packet = 1'b1;
					end
				end
			end
			tgarle_pkg::PH_PACKET: go_packet = 1'b1;
			tgarle_pkg::PH_RAW, tgarle_pkg::PH_COLOR: begin
				if (chan_idx < 2'd3) begin
					color_acc = color_acc | (24'(b) << (8 * chan_idx));
					chan_idx = chan_idx + 2'd1;
				end else begin
					chan_idx = '0;
					emit = 1'b1;
					if (dec_phase == tgarle_pkg::PH_COLOR) begin
						if (pkt_run) begin
							cnt = pkt_left;
							pkt_left = '0;
							dec_phase = tgarle_pkg::PH_PACKET;
						end else begin
							pkt_left = pkt_left - 8'd1;
							if (pkt_left == 0)
								dec_phase = tgarle_pkg::PH_PACKET;
						end
					end
				end
			end
			default: ;
		endcase
		if (go_packet) begin
			left = tot - pix_count;
			pkt_run = b[7];
			pkt_left = {1'b0, b[6:0]} + 8'd1;
			// clip at the image end
			if (32'(pkt_left) > left)
				pkt_left = left[7:0];
			chan_idx = '0;
			color_acc = '0;
			dec_phase = tgarle_pkg::PH_COLOR;
		end
		if (emit) begin
			hit = 1'b1;
			res.status = tgarle_pkg::ST_PIXEL;
			res.pixel_index = pix_count;
			res.repeat_count = cnt;
			res.blue = color_acc[7:0];
			res.green = color_acc[15:8];
			res.red = color_acc[23:16];
			res.alpha = b;
			pix_count = pix_count + 32'(cnt);
			res.image_done = (pix_count >= tot);
			if (pix_count >= tot)
				dec_phase = tgarle_pkg::PH_DONE;
			color_acc = '0;
		end
	endtask

	task automatic push_byte(input logic [7:0] v, input logic first);
		tgarle_pkg::in_t beat;
		beat.file_byte = v;
		beat.first_byte = first;
		file_bytes.push_back(beat);
		phase_items++;
	endtask

	function automatic logic [7:0] rand_chan();
		case ($urandom_range(4))
			0: return 8'h00;
			1: return 8'hFF;
			default: return 8'($urandom);
		endcase
	endfunction

	task automatic push_header(input logic [7:0] kind, input logic [15:0] w,
			input logic [15:0] h, input logic [7:0] bpp, input logic flag);
		logic [7:0] v;
		for (int i = 0; i < tgarle_pkg::HDR_LEN; i++) begin
			case (5'(i))
				tgarle_pkg::OFF_KIND: v = kind;
				tgarle_pkg::OFF_WIDTH_LO: v = w[7:0];
				tgarle_pkg::OFF_WIDTH_HI: v = w[15:8];
				tgarle_pkg::OFF_HEIGHT_LO: v = h[7:0];
				tgarle_pkg::OFF_HEIGHT_HI: v = h[15:8];
				tgarle_pkg::OFF_BPP: v = bpp;
				default: v = 8'($urandom);
			endcase
			push_byte(v, flag && i == 0);
		end
	endtask

	task automatic push_image(input logic [7:0] kind, input logic [31:0] tot, input logic cut);
		int start;
		int n;
		int m;
		int cnt;
		int pk;
		logic [31:0] left;
		logic run;
		start = file_bytes.size();
		if (kind == tgarle_pkg::KIND_RAW) begin
			n = (tot > 40) ? $urandom_range(1, 40) : int'(tot);
			// a pixel past the end is dropped by the block
			if (n == int'(tot) && $urandom_range(3) == 0)
				n++;
			repeat (n * 4) push_byte(rand_chan(), 1'b0);
		end else begin
			left = tot;
			pk = 0;
			while (left != 0 && pk < MAX_PACKETS) begin
				run = 1'($urandom_range(1));
				if (run)
					cnt = $urandom_range(1) ? $urandom_range(7) : $urandom_range(127);
				else if ($urandom_range(19) == 0 && tot < 256)
					cnt = 127;
				else
					cnt = $urandom_range(7);
				n = (32'(cnt + 1) > left) ? int'(left) : cnt + 1;
				m = n;
				if (run)
					m = 1;
				else if (n < cnt + 1 && $urandom_range(1))
					m = (cnt + 1 > n + 3) ? n + 3 : cnt + 1;
				push_byte({run, 7'(cnt)}, 1'b0);
				repeat (m * 4) push_byte(rand_chan(), 1'b0);
				left = left - 32'(n);
				pk++;
			end
			if (left == 0 && $urandom_range(3) == 0)
				repeat ($urandom_range(1, 5)) push_byte(8'($urandom), 1'b0);
		end
		// drop the tail; the next file restarts the parse
		if (cut && file_bytes.size() - start > 1)
			repeat ($urandom_range(1, file_bytes.size() - start - 1))
				void'(file_bytes.pop_back());
	endtask

	task automatic send_file();
		int sel;
		logic [15:0] w;
		logic [15:0] h;
		logic [7:0] kind;
		logic [7:0] bpp;
		logic bad;
		sel = $urandom_range(99);
		w = size_cfg.expected_width;
		h = size_cfg.expected_height;
		bpp = tgarle_pkg::BPP_32;
		kind = $urandom_range(1) ? tgarle_pkg::KIND_RLE : tgarle_pkg::KIND_RAW;
		bad = 1'b0;
		if (sel >= 93) begin
			repeat ($urandom_range(1, 30)) push_byte(8'($urandom), $urandom_range(9) == 0);
			return;
		end
		if (sel >= 70 && sel < 76) begin
			if ($urandom_range(1))
				w ^= 16'(1) << $urandom_range(15);
			else
				h ^= 16'(1) << $urandom_range(15);
			bad = 1'b1;
		end else if (sel >= 76 && sel < 80) begin
			if ($urandom_range(1))
				bpp = 8'd24;
			else
				do bpp = 8'($urandom); while (bpp == tgarle_pkg::BPP_32);
			bad = 1'b1;
		end else if (sel >= 80 && sel < 86) begin
			do kind = 8'($urandom);
			while (kind == tgarle_pkg::KIND_RAW || kind == tgarle_pkg::KIND_RLE);
			// size error takes priority over the type error
			if ($urandom_range(2) == 0)
				w ^= 16'(1) << $urandom_range(15);
			bad = 1'b1;
		end
		push_header(kind, w, h, bpp, 1'b1);
		files_sent++;
		if (bad)
			repeat ($urandom_range(1, 6)) push_byte(8'($urandom), 1'b0);
		else
			push_image(kind, 32'(w) * 32'(h), sel >= 86);
	endtask

	task automatic apb_write(input logic idx, input logic [15:0] val);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= {16'd0, val};
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (idx == tgarle_pkg::REG_WIDTH)
			size_cfg.expected_width = val;
		else
			size_cfg.expected_height = val;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic drain();
		while (file_bytes.size() != 0 || byte_valid)
			@(posedge clk);
		while (pixel_expect.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	always @(negedge clk) begin
		if (!arst_n) begin
			byte_valid <= 1'b0;
		end else if (!byte_valid || byte_taken) begin
			if (file_bytes.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
				byte_valid <= 1'b1;
				byte_data <= file_bytes.pop_front();
			end else begin
				byte_valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		pix_ready <= arst_n && ($urandom_range(99) >= rx_stall_pct);
	end

	always @(posedge clk) begin
		logic hit;
		tgarle_pkg::out_t res;
		byte_taken <= byte_valid && byte_ready;
		if (arst_n && byte_valid && byte_ready) begin
			bytes_in++;
			decode_byte(byte_data, hit, res);
			if (hit)
				pixel_expect.push_back(res);
		end
	end

	always @(posedge clk) begin
		tgarle_pkg::out_t want;
		if (arst_n && pix_valid && pix_ready) begin
			if (pix_data.status == tgarle_pkg::ST_PIXEL) begin
				pixel_beats++;
				if (pix_data.repeat_count > 1)
					run_beats++;
				if (pix_data.image_done)
					images_done++;
			end else begin
				header_rejects++;
			end
			if (pixel_expect.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected result beat, expected none, got %h", $time, pix_data);
			end else begin
				want = pixel_expect.pop_front();
				if (pix_data !== want) begin
					mismatches++;
					$display("%0t: mismatch expected st=%0d idx=%0d rep=%0d bgra=%h_%h_%h_%h done=%0b",
						$time, want.status, want.pixel_index, want.repeat_count, want.blue,
						want.green, want.red, want.alpha, want.image_done);
					$display("%0t:          actual st=%0d idx=%0d rep=%0d bgra=%h_%h_%h_%h done=%0b",
						$time, pix_data.status, pix_data.pixel_index, pix_data.repeat_count,
						pix_data.blue, pix_data.green, pix_data.red, pix_data.alpha,
						pix_data.image_done);
				end
			end
		end
	end

	initial begin
		static logic [15:0] phase_w [NUM_PHASES] = '{16'd1, 16'd3, 16'd65535, 16'd5,
			16'd1, 16'd8, 16'd65535, 16'd1};
		static logic [15:0] phase_h [NUM_PHASES] = '{16'd1, 16'd2, 16'd65535, 16'd4,
			16'd7, 16'd3, 16'd1, 16'd1};
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// parse from reset without a start flag: 1x1 raw image, extreme channels
		push_header(tgarle_pkg::KIND_RAW, 16'd1, 16'd1, tgarle_pkg::BPP_32, 1'b0);
		push_byte(8'hFF, 1'b0);
		push_byte(8'h00, 1'b0);
		push_byte(8'hFF, 1'b0);
		push_byte(8'h00, 1'b0);
		push_byte(8'hA5, 1'b0);
		push_byte(8'h5A, 1'b0);
		drain();

		for (int p = 0; p < NUM_PHASES; p++) begin
			case (p % 4)
				0: begin tx_idle_pct = 0; rx_stall_pct = 0; end
				1: begin tx_idle_pct = 69; rx_stall_pct = 0; end
				2: begin tx_idle_pct = 0; rx_stall_pct = 69; end
				default: begin tx_idle_pct = 20; rx_stall_pct = 20; end
			endcase
			if (p > 0) begin
				apb_write(tgarle_pkg::REG_WIDTH, phase_w[p]);
				apb_write(tgarle_pkg::REG_HEIGHT, phase_h[p]);
			end
			phase_items = 0;
			while (phase_items < ITEMS_PER_PHASE)
				send_file();
			// hold the sender until every result beat is back
			drain();
		end

		$display("Covered %0d file bytes in %0d files over %0d size settings.",
			bytes_in, files_sent, NUM_PHASES);
		$display("Saw %0d pixel beats (%0d runs), %0d complete images, %0d header rejects.",
			pixel_beats, run_beats, images_done, header_rejects);
		if (mismatches == 0 && pixel_expect.size() == 0) begin
			$display("[tga_rle_image_decoder] OK");
		end else begin
			$display("[tga_rle_image_decoder] ERROR");
		end
		$finish;
	end

endmodule
